// File: hdl/assert_macros.svh
// Assertion macros shared by the adaptive sensor trigger RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define AST_ASSERT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, checked outside reset.
`define AST_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define AST_ASSERT(lbl, clk, rstn, ante, cons)
`define AST_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// File: hdl/ast_pkg.sv
// Shared types and constants for the adaptive sensor trigger.
// Used by ast_stats, ast_detect and the adaptive_sensor_trigger top level.
package ast_pkg;

  // Mode codes
  localparam logic [1:0] MODE_HALL    = 2'd0;
  localparam logic [1:0] MODE_PHOTO   = 2'd1;
  localparam logic [1:0] MODE_PLUNGER = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_SENSOR_MODE   = 2'd0;
  localparam logic [1:0] CFG_CALIBRATING   = 2'd1;
  localparam logic [1:0] CFG_PEAK_FRACTION = 2'd2;

  localparam logic [7:0] PEAK_FRACTION_RESET = 8'd90;

  // Filter coefficients, 16 fraction bits
  localparam int         COEF_FRAC  = 16;
  localparam logic [15:0] K_AVG_NEW  = 16'd655;
  localparam logic [15:0] K_DEV_NEW  = 16'd3277;
  localparam logic [16:0] K_THR_GAIN = 17'd75366;
  localparam int         K_HALF16   = 32768;

  localparam logic [2:0] QUIET_NEEDED = 3'd5;
  localparam logic [2:0] QUIET_MAX    = 3'd7;

  // Per-sample decision inputs handed from the statistics pipe to the detector
  typedef struct packed {
    logic first;       // first sample after reset
    logic above;       // deviation above the adaptive threshold
    logic over_level;  // twice the sample above the level threshold
    logic under_level; // twice the sample below the level threshold
  } det_flags_t;

  typedef struct packed {
    logic triggered;
    logic active;
    logic settled;
  } det_res_t;

endpackage

// File: hdl/ast_stats.sv
// Three-stage statistics pipe: running average and deviation, smoothed and
// peak deviation, threshold products. Depends on ast_pkg and assert_macros.svh.
`include "assert_macros.svh"
module ast_stats import ast_pkg::*; #(
  parameter int SAMPLE_BITS   = 10,
  parameter int FRACTION_BITS = 8
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 calibrating,
  input  logic [1:0]                           sensor_mode,
  input  logic [7:0]                           peak_fraction,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [SAMPLE_BITS-1:0]               in_sample,
  output logic                                 st_valid,
  input  logic                                 st_ready,
  output det_flags_t                           st_flags,
  output logic [SAMPLE_BITS+FRACTION_BITS-1:0] st_dev
);

  localparam int VW = SAMPLE_BITS + FRACTION_BITS;
  localparam int MW = VW + COEF_FRAC + 2;
  localparam int GW = VW + 17;
  localparam int BW = VW + 8;
  localparam logic signed [MW-1:0] RND = MW'(K_HALF16);

  // Long-lived state
  logic [VW-1:0]          avg_r;
  logic                   seen_r;
  logic [VW-1:0]          sdev_r;
  logic [VW-1:0]          peak_r;
  logic [SAMPLE_BITS:0]   low_r;
  logic [SAMPLE_BITS-1:0] high_r;
  logic [SAMPLE_BITS:0]   lvl_r;

  // Pipe stages
  logic          v1_r, v2_r, v3_r;
  det_flags_t    f1_r, f2_r, f3_r;
  logic [VW-1:0] dev1_r, dev2_r, dev3_r;
  logic [VW-1:0] smix2_r, peak2_r;
  logic [VW:0]   thra3_r;
  logic [VW-1:0] thrb3_r;

  logic en1, en2, en3, acc;

  // Stage 1 signals
  logic [VW-1:0]          sq;
  logic signed [VW:0]     avg_delta;
  logic signed [MW-1:0]   avg_prod, avg_step;
  logic [VW-1:0]          avg_mix, avg_nxt, dev_nxt;
  logic [SAMPLE_BITS:0]   low_nxt, lvl_nxt, twice;
  logic [SAMPLE_BITS-1:0] high_nxt;

  // Stage 2 signals
  logic signed [VW:0]   sd_delta;
  logic signed [MW-1:0] sd_prod, sd_step;
  logic [VW-1:0]        smix, peak_nxt;

  // Stage 3 signals
  logic [GW-1:0] thra_prod;
  logic [BW-1:0] thrb_prod;

  assign en3      = !v3_r || st_ready;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;
  assign acc      = in_valid && en1;

  always_comb begin
    sq        = {in_sample, {FRACTION_BITS{1'b0}}};
    avg_delta = $signed({1'b0, sq}) - $signed({1'b0, avg_r});
    avg_prod  = avg_delta * $signed({1'b0, K_AVG_NEW});
    avg_step  = (avg_prod + RND) >>> COEF_FRAC;
    avg_mix   = avg_r + avg_step[VW-1:0];
    avg_nxt   = seen_r ? avg_mix : sq;
    dev_nxt   = (sq >= avg_nxt) ? sq - avg_nxt : avg_nxt - sq;
    low_nxt   = ({1'b0, in_sample} < low_r) ? {1'b0, in_sample} : low_r;
    high_nxt  = (in_sample > high_r) ? in_sample : high_r;
    lvl_nxt   = calibrating ? low_nxt + {1'b0, high_nxt} : lvl_r;
    twice     = {in_sample, 1'b0};
  end

  always_comb begin
    sd_delta = $signed({1'b0, dev1_r}) - $signed({1'b0, sdev_r});
    sd_prod  = sd_delta * $signed({1'b0, K_DEV_NEW});
    sd_step  = (sd_prod + RND) >>> COEF_FRAC;
    smix     = sdev_r + sd_step[VW-1:0];
    peak_nxt = (calibrating && dev1_r > peak_r) ? dev1_r : peak_r;
  end

  always_comb begin
    thra_prod = smix2_r * K_THR_GAIN;
    thrb_prod = peak2_r * peak_fraction;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
      seen_r <= 1'b0;
      avg_r  <= VW'(1) << (VW - 1);
      sdev_r <= '0;
      peak_r <= '0;
      low_r  <= (SAMPLE_BITS+1)'(1) << SAMPLE_BITS;
      high_r <= '0;
      lvl_r  <= (SAMPLE_BITS+1)'(1) << SAMPLE_BITS;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (acc) begin
        seen_r <= 1'b1;
        avg_r  <= avg_nxt;
        if (calibrating) begin
          low_r  <= low_nxt;
          high_r <= high_nxt;
          lvl_r  <= lvl_nxt;
        end
      end
      if (en2 && v1_r) begin
        // hall mode seeds the smoothed deviation on the first sample
        sdev_r <= (sensor_mode == MODE_HALL && f1_r.first) ? dev1_r : smix;
        peak_r <= peak_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      dev1_r            <= dev_nxt;
      f1_r.first        <= !seen_r;
      f1_r.above        <= 1'b0;
      f1_r.over_level   <= twice > lvl_nxt;
      f1_r.under_level  <= twice < lvl_nxt;
    end
    if (en2 && v1_r) begin
      dev2_r  <= dev1_r;
      f2_r    <= f1_r;
      smix2_r <= smix;
      peak2_r <= peak_nxt;
    end
    if (en3 && v2_r) begin
      dev3_r  <= dev2_r;
      f3_r    <= f2_r;
      thra3_r <= (VW+1)'((thra_prod + GW'(K_HALF16)) >> COEF_FRAC);
      thrb3_r <= VW'((thrb_prod + BW'(128)) >> 8);
    end
  end

  always_comb begin
    st_flags       = f3_r;
    st_flags.above = ({1'b0, dev3_r} > thra3_r) && (dev3_r > thrb3_r);
  end

  assign st_valid = v3_r;
  assign st_dev   = dev3_r;

  `AST_ASSERT(a_stall_full, clk, rst_n, !in_ready, v1_r && v2_r && v3_r)
  `AST_ASSERT_NXT(a_seen_sticky, clk, rst_n, seen_r, seen_r)
  `AST_ASSERT_NXT(a_first_once, clk, rst_n, acc && seen_r, !f1_r.first)

endmodule

// File: hdl/ast_detect.sv
// Mode detector: hall quiet counter, photo level, plunger release logic.
// Depends on ast_pkg and assert_macros.svh.
`include "assert_macros.svh"
module ast_detect import ast_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [1:0] sensor_mode,
  input  logic       adv,
  input  det_flags_t flags,
  output det_res_t   res
);

  logic [2:0] quiet_r, quiet_nxt, quiet_inc;
  logic       last_act_r, last_stab_r;

  always_comb begin
    quiet_inc     = (quiet_r < QUIET_MAX) ? quiet_r + 3'd1 : quiet_r;
    quiet_nxt     = quiet_r;
    res.triggered = 1'b0;
    res.active    = 1'b0;
    res.settled   = 1'b1;
    case (sensor_mode)
      MODE_HALL: begin
        if (!flags.first) begin
          if (flags.above) begin
            quiet_nxt   = '0;
            res.active  = 1'b1;
            res.settled = 1'b0;
          end else begin
            quiet_nxt   = quiet_inc;
            res.active  = !(quiet_inc > QUIET_NEEDED);
            res.settled = quiet_inc > QUIET_NEEDED;
          end
          res.triggered = res.active && !last_act_r;
        end
      end
      MODE_PHOTO: begin
        if (flags.first) begin
          res.active    = 1'b1;
          res.triggered = 1'b1;
        end else begin
          res.active    = flags.over_level;
          res.triggered = flags.over_level != last_act_r;
        end
      end
      MODE_PLUNGER: begin
        if (!flags.first) begin
          // fire on the unstable-to-stable transition
          res.settled   = flags.under_level;
          res.active    = flags.under_level && !last_stab_r;
          res.triggered = res.active;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quiet_r     <= '0;
      last_act_r  <= 1'b0;
      last_stab_r <= 1'b0;
    end else if (adv) begin
      quiet_r     <= quiet_nxt;
      last_act_r  <= res.active;
      last_stab_r <= res.settled;
    end
  end

  `AST_ASSERT_NXT(a_quiet_clear, clk, rst_n,
    adv && sensor_mode == MODE_HALL && !flags.first && flags.above, quiet_r == 3'd0)
  `AST_ASSERT(a_trig_rise, clk, rst_n,
    adv && sensor_mode == MODE_HALL && res.triggered, !last_act_r)

endmodule

// File: hdl/adaptive_sensor_trigger.sv
// Channel  | Direction | Payload
// in_      | slave     | tdata[SAMPLE_BITS-1:0] sample
// out_     | master    | tdata[0] triggered, [1] active, [2] settled, [3 +: SB+FB] deviation
// cfg_     | write     | addr 0 sensor_mode, 1 calibrating, 2 peak_fraction
//
// One sample per cycle sustained while out_tready is high; an input beat passes
// through three statistics stages (average, smoothing, threshold products) and
// the output register. Each stage holds its beat while the next is full, so
// input keeps flowing into empty stages while a result waits.
// Synchronous active-low reset restores all statistics to their start values.
// Top level; depends on ast_pkg, ast_stats and ast_detect.
module adaptive_sensor_trigger import ast_pkg::*; #(
  parameter int SAMPLE_BITS   = 10,
  parameter int FRACTION_BITS = 8,
  localparam int IN_W  = ((SAMPLE_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((SAMPLE_BITS + FRACTION_BITS + 3 + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [1:0]       cfg_addr,
  input  logic [7:0]       cfg_wdata,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // sample
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata   // triggered, active, settled, deviation
);

  localparam int VW = SAMPLE_BITS + FRACTION_BITS;

  logic [1:0] sensor_mode_r;
  logic       calibrating_r;
  logic [7:0] peak_fraction_r;

  logic          st_valid, st_ready;
  det_flags_t    st_flags;
  logic [VW-1:0] st_dev;
  det_res_t      res;
  logic          adv;

  logic             out_valid_r;
  logic [OUT_W-1:0] out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sensor_mode_r   <= MODE_HALL;
      calibrating_r   <= 1'b0;
      peak_fraction_r <= PEAK_FRACTION_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        CFG_SENSOR_MODE:   sensor_mode_r   <= cfg_wdata[1:0];
        CFG_CALIBRATING:   calibrating_r   <= cfg_wdata[0];
        CFG_PEAK_FRACTION: peak_fraction_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  ast_stats #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_stats (
    .clk           (clk),
    .rst_n         (rst_n),
    .calibrating   (calibrating_r),
    .sensor_mode   (sensor_mode_r),
    .peak_fraction (peak_fraction_r),
    .in_valid      (in_tvalid),
    .in_ready      (in_tready),
    .in_sample     (in_tdata[SAMPLE_BITS-1:0]),
    .st_valid      (st_valid),
    .st_ready      (st_ready),
    .st_flags      (st_flags),
    .st_dev        (st_dev)
  );

  assign st_ready = !out_valid_r || out_tready;
  assign adv      = st_valid && st_ready;

  ast_detect u_detect (
    .clk         (clk),
    .rst_n       (rst_n),
    .sensor_mode (sensor_mode_r),
    .adv         (adv),
    .flags       (st_flags),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (st_ready) begin
      out_valid_r <= st_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= OUT_W'({st_dev, res.settled, res.active, res.triggered});
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
